// File: sv/assert_macros.svh
// Assertion helpers used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/caem_pkg.sv
// ----------------------------------------------------------------------------
// caem_pkg
// Shared widths, constants, register indexes and the controller command bundle
// of the two-channel clamped adaptive EMA filter.
// ----------------------------------------------------------------------------
package caem_pkg;

   localparam int FRAC_BITS_DEF = 8;

   localparam int READ_W     = 16;   // signed temperature reading
   localparam int HUM_READ_W = 15;   // unsigned humidity reading
   localparam int VAL_W      = 17;   // internal filter value, signed
   localparam int HUM_W      = 16;   // humidity output
   localparam int DIV_W      = 11;   // calibration divisor
   localparam int LIMIT_W    = 3;    // fail limit and fail count
   localparam int CSR_IDX_W  = 2;

   localparam int TEMP_LO = -65536;
   localparam int TEMP_HI = 65535;
   localparam int HUM_LO  = 0;
   localparam int HUM_HI  = 65535;

   localparam logic [DIV_W-1:0]   DIV_RESET   = DIV_W'(256);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_DIV   = 2'd0,
      CSR_HUM_DIV    = 2'd1,
      CSR_FAIL_LIMIT = 2'd2
   } caem_csr_type;

   typedef struct packed {
      logic load;       // latch item, start divide
      logic div_step;   // one quotient bit
      logic sat_en;     // register saturated target
      logic step_en;    // register clamped step, alpha
      logic mul_en;     // register alpha * step
      logic commit;     // update filter state and result
   } caem_cmd_type;

endpackage

// File: sv/clamped_adaptive_ema_two_channel_top.sv
// Sequence: accept and load, restoring divide, saturate, clamp, multiply, commit.
// A new item is accepted only once the previous one has committed. The restoring
// divider gives one quotient bit per cycle, one divider per channel run in parallel.
// A finished result waits in its output register while the next item is computed.
// Reset: synchronous, active high; clears filters, started flags, fail counts and
// loads divisors 256 and fail limit 3.
// ----------------------------------------------------------------------------
// clamped_adaptive_ema_two_channel_top
// Two-channel slew-limited adaptive EMA: calibration divide, step clamp,
// alpha select by step size and invalid-sample fault counting.
// ----------------------------------------------------------------------------
module clamped_adaptive_ema_two_channel_top #(
   parameter int FRAC_BITS = caem_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_temp_valid,
   input  logic signed [caem_pkg::READ_W-1:0]    req_temp_reading,
   input  logic                                  req_hum_valid,
   input  logic [caem_pkg::HUM_READ_W-1:0]       req_hum_reading,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [caem_pkg::VAL_W-1:0]     rsp_temp_filtered,
   output logic [caem_pkg::HUM_W-1:0]            rsp_hum_filtered,
   output logic                                  rsp_temp_fault,
   output logic                                  rsp_hum_fault,
   input  logic                                  csr_we,
   input  logic [caem_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [caem_pkg::DIV_W-1:0]            csr_wdata
);
   import caem_pkg::*;

   localparam int QUOT_W = READ_W + FRAC_BITS;

   caem_cmd_type cmd;

   caem_ctrl #(.QUOT_W(QUOT_W)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   caem_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_temp_valid    (req_temp_valid),
      .req_temp_reading  (req_temp_reading),
      .req_hum_valid     (req_hum_valid),
      .req_hum_reading   (req_hum_reading),
      .rsp_temp_filtered (rsp_temp_filtered),
      .rsp_hum_filtered  (rsp_hum_filtered),
      .rsp_temp_fault    (rsp_temp_fault),
      .rsp_hum_fault     (rsp_hum_fault)
   );

endmodule

// File: sv/caem_div.sv
// ----------------------------------------------------------------------------
// caem_div
// Restoring divider, one quotient bit per cycle while step is high: |reading| * 2^F / divisor.
// ----------------------------------------------------------------------------
module caem_div #(
   parameter int QUOT_W = caem_pkg::READ_W + caem_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              load,
   input  logic                              step,
   input  logic signed [caem_pkg::READ_W-1:0] reading,
   input  logic [caem_pkg::DIV_W-1:0]        divisor,
   output logic [QUOT_W-1:0]                 quot,
   output logic                              quot_neg
);
   import caem_pkg::*;

   localparam int REM_W = DIV_W + 1;
   localparam int ACC_W = REM_W + QUOT_W;

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic              neg_ff, neg_in;
   logic [READ_W-1:0] mag;
   logic [ACC_W-1:0]  shifted;
   logic [REM_W:0]    trial;

   assign mag     = reading[READ_W-1] ? READ_W'(-reading) : reading;
   assign shifted = acc_ff << 1;
   assign trial   = {1'b0, shifted[ACC_W-1:QUOT_W]} - {2'b00, div_ff};

   always_comb begin
      acc_in = acc_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      if (load) begin
         acc_in = {{REM_W{1'b0}}, mag, {(QUOT_W-READ_W){1'b0}}};
         div_in = (divisor == '0) ? DIV_W'(1) : divisor;
         neg_in = reading[READ_W-1];
      end else if (step) begin
         if (!trial[REM_W]) begin
            acc_in = {trial[REM_W-1:0], shifted[QUOT_W-1:1], 1'b1};
         end else begin
            acc_in = shifted;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign quot     = acc_ff[QUOT_W-1:0];
   assign quot_neg = neg_ff;

endmodule

// File: sv/caem_filt.sv
// ----------------------------------------------------------------------------
// caem_filt
// One channel: saturate the calibrated sample, clamp the step, pick alpha,
// move the filter value and count invalid samples.
// ----------------------------------------------------------------------------
module caem_filt #(
   parameter int FRAC_BITS = caem_pkg::FRAC_BITS_DEF,
   parameter int QUOT_W    = caem_pkg::READ_W + caem_pkg::FRAC_BITS_DEF,
   parameter int CLAMP     = 640,
   parameter int SMALL_T   = 102,
   parameter int MEDIUM_T  = 307,
   parameter int VAL_LO    = caem_pkg::TEMP_LO,
   parameter int VAL_HI    = caem_pkg::TEMP_HI
) (
   input  logic                               clock,
   input  logic                               reset,
   input  caem_pkg::caem_cmd_type             cmd,
   input  logic                               sample_valid,
   input  logic [QUOT_W-1:0]                  quot,
   input  logic                               quot_neg,
   input  logic [caem_pkg::LIMIT_W-1:0]       fail_limit,
   output logic signed [caem_pkg::VAL_W-1:0]  value,
   output logic                               fault
);
   import caem_pkg::*;

   localparam int SQ_W    = QUOT_W + 1;
   localparam int STEP_W  = VAL_W + 1;
   localparam int MAG_W   = FRAC_BITS + 3;
   localparam int ALPHA_W = FRAC_BITS;
   localparam int PROD_W  = MAG_W + ALPHA_W;
   localparam int MOVE_W  = PROD_W + 1 - FRAC_BITS;

   localparam int ALPHA_SLOW = ((20 << FRAC_BITS) + 50) / 100;
   localparam int ALPHA_MID  = ((35 << FRAC_BITS) + 50) / 100;
   localparam int ALPHA_FAST = ((55 << FRAC_BITS) + 50) / 100;

   localparam logic signed [SQ_W-1:0]   SQ_LO   = SQ_W'(VAL_LO);
   localparam logic signed [SQ_W-1:0]   SQ_HI   = SQ_W'(VAL_HI);
   localparam logic signed [STEP_W-1:0] ST_LO   = STEP_W'(VAL_LO);
   localparam logic signed [STEP_W-1:0] ST_HI   = STEP_W'(VAL_HI);
   localparam logic signed [STEP_W-1:0] CLAMP_P = STEP_W'(CLAMP);
   localparam logic signed [STEP_W-1:0] CLAMP_N = STEP_W'(-CLAMP);
   localparam logic [MAG_W-1:0]         SMALL_M = MAG_W'(SMALL_T);
   localparam logic [MAG_W-1:0]         MED_M   = MAG_W'(MEDIUM_T);
   localparam logic [PROD_W:0]          HALF_Q  = {{PROD_W{1'b0}}, 1'b1} << (FRAC_BITS - 1);

   logic signed [VAL_W-1:0] tgt_ff, tgt_in;
   logic                    sneg_ff, sneg_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [ALPHA_W-1:0]      alpha_ff, alpha_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic                    started_ff, started_in;
   logic [LIMIT_W-1:0]      count_ff, count_in;
   logic                    fault_ff, fault_in;

   logic signed [SQ_W-1:0]   sq;
   logic signed [STEP_W-1:0] step_raw, step_clamped, step_abs;
   logic [PROD_W:0]          rounded;
   logic [MOVE_W-1:0]        move;
   logic signed [STEP_W-1:0] sum, new_val;
   logic [LIMIT_W:0]         cnt_inc;

   // calibrated sample back to signed, then saturate to the channel range
   assign sq = quot_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

   always_comb begin
      if (sq < SQ_LO) begin
         tgt_in = SQ_LO[VAL_W-1:0];
      end else if (sq > SQ_HI) begin
         tgt_in = SQ_HI[VAL_W-1:0];
      end else begin
         tgt_in = sq[VAL_W-1:0];
      end
   end

   assign step_raw = $signed({tgt_ff[VAL_W-1], tgt_ff}) - $signed({value_ff[VAL_W-1], value_ff});

   always_comb begin
      if (step_raw > CLAMP_P) begin
         step_clamped = CLAMP_P;
      end else if (step_raw < CLAMP_N) begin
         step_clamped = CLAMP_N;
      end else begin
         step_clamped = step_raw;
      end
   end

   assign sneg_in  = step_clamped[STEP_W-1];
   assign step_abs = sneg_in ? -step_clamped : step_clamped;
   assign mag_in   = step_abs[MAG_W-1:0];

   always_comb begin
      if (mag_in <= SMALL_M) begin
         alpha_in = ALPHA_W'(ALPHA_SLOW);
      end else if (mag_in <= MED_M) begin
         alpha_in = ALPHA_W'(ALPHA_MID);
      end else begin
         alpha_in = ALPHA_W'(ALPHA_FAST);
      end
   end

   assign prod_in = PROD_W'(alpha_ff) * PROD_W'(mag_ff);

   // round magnitude half away from zero, then put the sign back
   assign rounded = {1'b0, prod_ff} + HALF_Q;
   assign move    = rounded[PROD_W:FRAC_BITS];
   assign sum     = sneg_ff
                    ? $signed({value_ff[VAL_W-1], value_ff})
                      - $signed({{(STEP_W-MOVE_W){1'b0}}, move})
                    : $signed({value_ff[VAL_W-1], value_ff})
                      + $signed({{(STEP_W-MOVE_W){1'b0}}, move});

   always_comb begin
      if (sum < ST_LO) begin
         new_val = ST_LO;
      end else if (sum > ST_HI) begin
         new_val = ST_HI;
      end else begin
         new_val = sum;
      end
   end

   // count plus one compared without wrap
   assign cnt_inc = (LIMIT_W+1)'(count_ff) + (LIMIT_W+1)'(1);

   always_comb begin
      value_in   = value_ff;
      started_in = started_ff;
      count_in   = count_ff;
      fault_in   = fault_ff;
      if (cmd.commit) begin
         if (sample_valid) begin
            value_in   = started_ff ? new_val[VAL_W-1:0] : tgt_ff;
            started_in = 1'b1;
            count_in   = '0;
            fault_in   = 1'b0;
         end else if (cnt_inc >= {1'b0, fail_limit}) begin
            count_in = '0;
            fault_in = 1'b1;
         end else begin
            count_in = cnt_inc[LIMIT_W-1:0];
            fault_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sat_en) begin
         tgt_ff <= tgt_in;
      end
      if (cmd.step_en) begin
         sneg_ff  <= sneg_in;
         mag_ff   <= mag_in;
         alpha_ff <= alpha_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff   <= '0;
         started_ff <= 1'b0;
         count_ff   <= '0;
         fault_ff   <= 1'b0;
      end else begin
         value_ff   <= value_in;
         started_ff <= started_in;
         count_ff   <= count_in;
         fault_ff   <= fault_in;
      end
   end

   assign value = value_ff;
   assign fault = fault_ff;

endmodule

// File: sv/caem_dp.sv
// ----------------------------------------------------------------------------
// caem_dp
// Datapath: config registers, one divider and one filter per channel.
// Both channels run side by side under the same commands.
// ----------------------------------------------------------------------------
module caem_dp #(
   parameter int FRAC_BITS = caem_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  caem_pkg::caem_cmd_type                cmd,
   input  logic                                  csr_we,
   input  logic [caem_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [caem_pkg::DIV_W-1:0]            csr_wdata,
   input  logic                                  req_temp_valid,
   input  logic signed [caem_pkg::READ_W-1:0]    req_temp_reading,
   input  logic                                  req_hum_valid,
   input  logic [caem_pkg::HUM_READ_W-1:0]       req_hum_reading,
   output logic signed [caem_pkg::VAL_W-1:0]     rsp_temp_filtered,
   output logic [caem_pkg::HUM_W-1:0]            rsp_hum_filtered,
   output logic                                  rsp_temp_fault,
   output logic                                  rsp_hum_fault
);
   import caem_pkg::*;

   localparam int QUOT_W = READ_W + FRAC_BITS;

   localparam int TEMP_CLAMP  = ((5 << FRAC_BITS) + 1) / 2;
   localparam int TEMP_SMALL  = ((4 << FRAC_BITS) + 5) / 10;
   localparam int TEMP_MEDIUM = ((12 << FRAC_BITS) + 5) / 10;
   localparam int HUM_CLAMP   = 6 << FRAC_BITS;
   localparam int HUM_SMALL   = 1 << FRAC_BITS;
   localparam int HUM_MEDIUM  = ((7 << FRAC_BITS) + 1) / 2;

   logic [DIV_W-1:0]   temp_div_ff, temp_div_in;
   logic [DIV_W-1:0]   hum_div_ff, hum_div_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               temp_valid_ff, hum_valid_ff;

   logic [QUOT_W-1:0]       temp_quot, hum_quot;
   logic                    temp_qneg, hum_qneg;
   logic signed [VAL_W-1:0] hum_value;

   always_comb begin
      temp_div_in = temp_div_ff;
      hum_div_in  = hum_div_ff;
      limit_in    = limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TEMP_DIV:   temp_div_in = csr_wdata;
            CSR_HUM_DIV:    hum_div_in  = csr_wdata;
            CSR_FAIL_LIMIT: limit_in    = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_div_ff <= DIV_RESET;
         hum_div_ff  <= DIV_RESET;
         limit_ff    <= LIMIT_RESET;
      end else begin
         temp_div_ff <= temp_div_in;
         hum_div_ff  <= hum_div_in;
         limit_ff    <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         temp_valid_ff <= req_temp_valid;
         hum_valid_ff  <= req_hum_valid;
      end
   end

   caem_div #(.QUOT_W(QUOT_W)) u_temp_div (
      .clock    (clock),
      .load     (cmd.load),
      .step     (cmd.div_step),
      .reading  (req_temp_reading),
      .divisor  (temp_div_ff),
      .quot     (temp_quot),
      .quot_neg (temp_qneg)
   );

   caem_div #(.QUOT_W(QUOT_W)) u_hum_div (
      .clock    (clock),
      .load     (cmd.load),
      .step     (cmd.div_step),
      .reading  ($signed({1'b0, req_hum_reading})),
      .divisor  (hum_div_ff),
      .quot     (hum_quot),
      .quot_neg (hum_qneg)
   );

   caem_filt #(
      .FRAC_BITS (FRAC_BITS),
      .QUOT_W    (QUOT_W),
      .CLAMP     (TEMP_CLAMP),
      .SMALL_T   (TEMP_SMALL),
      .MEDIUM_T  (TEMP_MEDIUM),
      .VAL_LO    (TEMP_LO),
      .VAL_HI    (TEMP_HI)
   ) u_temp_filt (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sample_valid (temp_valid_ff),
      .quot         (temp_quot),
      .quot_neg     (temp_qneg),
      .fail_limit   (limit_ff),
      .value        (rsp_temp_filtered),
      .fault        (rsp_temp_fault)
   );

   caem_filt #(
      .FRAC_BITS (FRAC_BITS),
      .QUOT_W    (QUOT_W),
      .CLAMP     (HUM_CLAMP),
      .SMALL_T   (HUM_SMALL),
      .MEDIUM_T  (HUM_MEDIUM),
      .VAL_LO    (HUM_LO),
      .VAL_HI    (HUM_HI)
   ) u_hum_filt (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sample_valid (hum_valid_ff),
      .quot         (hum_quot),
      .quot_neg     (hum_qneg),
      .fail_limit   (limit_ff),
      .value        (hum_value),
      .fault        (rsp_hum_fault)
   );

   // humidity never goes negative, top bit is always zero
   assign rsp_hum_filtered = hum_value[HUM_W-1:0];

endmodule

// File: sv/caem_ctrl.sv
// ----------------------------------------------------------------------------
// caem_ctrl
// Sequencer: accept, divide, saturate, clamp, multiply, commit. Owns the
// result valid flag so the next item can start while a result waits.
// ----------------------------------------------------------------------------
module caem_ctrl #(
   parameter int QUOT_W = caem_pkg::READ_W + caem_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output caem_pkg::caem_cmd_type cmd
);
   import caem_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_SAT  = 6'b000100,
      ST_STEP = 6'b001000,
      ST_MUL  = 6'b010000,
      ST_UPD  = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_W'(QUOT_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            cmd.sat_en = 1'b1;
            state_in   = ST_STEP;
         end
         ST_STEP: begin
            cmd.step_en = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_UPD;
         end
         ST_UPD: begin
            // hold here until the result register is free
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/caem_port_chk.sv
// ----------------------------------------------------------------------------
// caem_port_chk
// Port-level checks of the EMA filter top, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module caem_port_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [caem_pkg::VAL_W-1:0] rsp_temp_filtered,
   input logic [caem_pkg::HUM_W-1:0]        rsp_hum_filtered,
   input logic                              rsp_temp_fault,
   input logic                              rsp_hum_fault
);

   // stalled result holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temp_filtered) && $stable(rsp_hum_filtered) && $stable(rsp_temp_fault) && $stable(rsp_hum_fault), "result changed while stalled")

   // an accepted item keeps the block busy through the divide
   `ASSERT_CLK(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready ##1 !req_ready, "input ready too soon after accept")

   // a new result only shows up at the end of a busy stretch
   `ASSERT_CLK(a_rsp_after_work, clock, reset, $rose(rsp_valid) |-> $past(!req_ready), "result appeared while idle")

   // reset leaves the block idle and empty
   `ASSERT_CLK_NR(a_reset_state, clock, $past(reset) |-> !rsp_valid && req_ready, "bad state after reset")

endmodule

bind clamped_adaptive_ema_two_channel_top caem_port_chk u_port_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_temp_filtered (rsp_temp_filtered),
   .rsp_hum_filtered  (rsp_hum_filtered),
   .rsp_temp_fault    (rsp_temp_fault),
   .rsp_hum_fault     (rsp_hum_fault)
);

// File: tb/clamped_adaptive_ema_two_channel_top_test.sv
// ----------------------------------------------------------------------------
// clamped_adaptive_ema_two_channel_top_test
// Self-checking bench for the two-channel clamped adaptive EMA filter. A short
// scripted sequence hits the never-loaded state, extremes, fault pulses and divisor corners,
// then randomized phases with different register settings drive samples, many
// near the running filter values. Every result item is compared with a local
// fixed-point model of both filters and the fault counters, or with a result typed in its row.
// ----------------------------------------------------------------------------
module clamped_adaptive_ema_two_channel_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import caem_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam longint ONE  = longint'(1) << FRAC;
   localparam longint HALF = longint'(1) << (FRAC - 1);

   // round(c * 2^FRAC) for the filter constants
   localparam longint T_CLAMP     = ((longint'(5) << FRAC) + 1) / 2;
   localparam longint T_SMALL     = ((longint'(4) << FRAC) + 5) / 10;
   localparam longint T_MED       = ((longint'(12) << FRAC) + 5) / 10;
   localparam longint H_CLAMP     = 6 * ONE;
   localparam longint H_SMALL     = ONE;
   localparam longint H_MED       = ((longint'(7) << FRAC) + 1) / 2;
   localparam longint ALPHA_SLOW  = ((longint'(20) << FRAC) + 50) / 100;
   localparam longint ALPHA_MID   = ((longint'(35) << FRAC) + 50) / 100;
   localparam longint ALPHA_FAST  = ((longint'(55) << FRAC) + 50) / 100;

   localparam int PHASES          = 11;
   localparam int ITEMS_PER_PHASE = 121;
   localparam int SETTLE          = 4;
   localparam int TAIL_CYCLES     = 16 + FRAC + 16;
   localparam int HOLD_OFF        = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SCRIPT_LEN      = 33;

   typedef struct packed {
      logic                      temp_valid;
      logic signed [READ_W-1:0]  temp_reading;
      logic                      hum_valid;
      logic [HUM_READ_W-1:0]     hum_reading;
   } sample_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]   temp_filtered;
      logic [HUM_W-1:0]          hum_filtered;
      logic                      temp_fault;
      logic                      hum_fault;
   } sensor_out_type;

   typedef enum logic [1:0] {
      ROW_ITEM    = 2'd0,   // item, result from the model
      ROW_CHECKED = 2'd1,   // item, result typed in the row
      ROW_CSR     = 2'd2    // register write
   } row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      caem_csr_type     csr_sel;
      logic [DIV_W-1:0] csr_val;
      sample_type       stim;
      sensor_out_type   typed_out;
   } script_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_temp_valid;
   logic signed [READ_W-1:0] req_temp_reading;
   logic                     req_hum_valid;
   logic [HUM_READ_W-1:0]    req_hum_reading;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [VAL_W-1:0]  rsp_temp_filtered;
   logic [HUM_W-1:0]         rsp_hum_filtered;
   logic                     rsp_temp_fault;
   logic                     rsp_hum_fault;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [DIV_W-1:0]         csr_wdata;

   // filter model state and its copy of the registers
   longint      temp_est = 0;
   longint      hum_est = 0;
   bit          temp_loaded = 1'b0;
   bit          hum_loaded = 1'b0;
   int          temp_misses = 0;
   int          hum_misses = 0;
   int unsigned cfg_temp_div = 256;
   int unsigned cfg_hum_div = 256;
   int unsigned cfg_limit = 3;

   sensor_out_type pending_outputs[$];

   int  errors = 0;
   int  items_sent = 0;
   int  results_checked = 0;
   int  regs_written = 0;
   int  temp_faults = 0;
   int  hum_faults = 0;
   int  alpha_hits[3] = '{0, 0, 0};
   int  temp_burst = 0;
   int  hum_burst = 0;
   int  quiet_cycles = 0;
   int  directed_items;
   bit  items_open = 1'b0;
   bit  csr_open = 1'b0;
   bit  calm = 1'b0;
   bit  squeeze_req = 1'b0;

   clamped_adaptive_ema_two_channel_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_temp_valid    (req_temp_valid),
      .req_temp_reading  (req_temp_reading),
      .req_hum_valid     (req_hum_valid),
      .req_hum_reading   (req_hum_reading),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_temp_filtered (rsp_temp_filtered),
      .rsp_hum_filtered  (rsp_hum_filtered),
      .rsp_temp_fault    (rsp_temp_fault),
      .rsp_hum_fault     (rsp_hum_fault),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic longint clip_range(longint v, longint lo, longint hi);
      if (v < lo) begin
         return lo;
      end else if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   function automatic longint scale_reading(longint raw, int unsigned dv,
                                            longint lo, longint hi);
      longint d;
      longint mag;
      longint q;
      d = (dv == 0) ? 1 : longint'(dv);   // zero divisor acts as one
      mag = (raw < 0) ? -raw : raw;
      q = (mag << FRAC) / d;
      return clip_range((raw < 0) ? -q : q, lo, hi);
   endfunction

   function automatic longint ema_move(longint cur, longint target, longint lim,
                                       longint thr_lo, longint thr_hi,
                                       longint lo, longint hi);
      longint diff;
      longint mag;
      longint gain;
      longint shift;
      diff = target - cur;
      if (diff > lim) diff = lim;
      if (diff < -lim) diff = -lim;
      mag = (diff < 0) ? -diff : diff;
      if (mag <= thr_lo) begin
         gain = ALPHA_SLOW;
         alpha_hits[0]++;
      end else if (mag <= thr_hi) begin
         gain = ALPHA_MID;
         alpha_hits[1]++;
      end else begin
         gain = ALPHA_FAST;
         alpha_hits[2]++;
      end
      shift = (gain * mag + HALF) >> FRAC;   // magnitude rounded half away
      return clip_range((diff < 0) ? cur - shift : cur + shift, lo, hi);
   endfunction

   // count plus one is compared unwrapped, so a lowered limit fires at once
   function automatic bit tally_invalid(inout int cnt);
      int c;
      bit fired;
      c = (cnt & 7) + 1;
      fired = (c >= int'(cfg_limit & 7));
      cnt = fired ? 0 : (c & 7);
      return fired;
   endfunction

   function automatic sensor_out_type advance_filters(sample_type s);
      sensor_out_type o;
      longint target;
      o = '0;
      if (s.temp_valid) begin
         target = scale_reading(longint'($signed(s.temp_reading)), cfg_temp_div,
                                TEMP_LO, TEMP_HI);
         temp_est = temp_loaded ? ema_move(temp_est, target, T_CLAMP, T_SMALL, T_MED,
                                           TEMP_LO, TEMP_HI) : target;
         temp_loaded = 1'b1;
         temp_misses = 0;
      end else begin
         o.temp_fault = tally_invalid(temp_misses);
      end
      if (s.hum_valid) begin
         target = scale_reading(longint'(s.hum_reading), cfg_hum_div, HUM_LO, HUM_HI);
         hum_est = hum_loaded ? ema_move(hum_est, target, H_CLAMP, H_SMALL, H_MED,
                                         HUM_LO, HUM_HI) : target;
         hum_loaded = 1'b1;
         hum_misses = 0;
      end else begin
         o.hum_fault = tally_invalid(hum_misses);
      end
      o.temp_filtered = temp_est[VAL_W-1:0];
      o.hum_filtered = hum_est[HUM_W-1:0];
      return o;
   endfunction

   // ------------------------------------------------------------- stimulus

   function automatic script_row_type row_item(logic tv, int tr, logic hv, int hr);
      script_row_type r;
      r = '0;
      r.kind = ROW_ITEM;
      r.csr_sel = CSR_TEMP_DIV;
      r.stim.temp_valid = tv;
      r.stim.temp_reading = READ_W'(tr);
      r.stim.hum_valid = hv;
      r.stim.hum_reading = HUM_READ_W'(hr);
      return r;
   endfunction

   function automatic script_row_type row_exp(logic tv, int tr, logic hv, int hr,
                                              int et, int eh, logic ft, logic fh);
      script_row_type r;
      r = row_item(tv, tr, hv, hr);
      r.kind = ROW_CHECKED;
      r.typed_out = '{VAL_W'(et), HUM_W'(eh), ft, fh};
      return r;
   endfunction

   function automatic script_row_type row_csr(caem_csr_type sel, int val);
      script_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.csr_sel = sel;
      r.csr_val = DIV_W'(val);
      return r;
   endfunction

   script_row_type script [SCRIPT_LEN] = '{
      row_exp(1'b0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0),         // never loaded: zero out
      row_exp(1'b0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0),
      row_exp(1'b0, 0, 1'b0, 0, 0, 0, 1'b1, 1'b1),         // third miss hits limit 3
      row_exp(1'b1, 32767, 1'b1, 32767, 32767, 32767, 1'b0, 1'b0),   // first load
      row_item(1'b1, -32768, 1'b1, 0),                      // full swing, clamped
      row_item(1'b0, -1, 1'b0, 32767),                      // invalid, all-ones data
      row_item(1'b0, 0, 1'b1, 25600),
      row_item(1'b1, 20480, 1'b0, 0),
      row_item(1'b1, -10240, 1'b1, 0),
      row_item(1'b0, 0, 1'b0, 0),
      row_item(1'b0, 0, 1'b0, 0),
      row_csr(CSR_FAIL_LIMIT, 1),                           // limit below running count
      row_item(1'b0, 0, 1'b0, 0),
      row_csr(CSR_FAIL_LIMIT, 0),                           // every miss faults
      row_item(1'b0, 0, 1'b1, 100),
      row_csr(CSR_TEMP_DIV, 0),                             // zero divisor
      row_csr(CSR_HUM_DIV, 0),
      row_csr(CSR_FAIL_LIMIT, 7),
      row_item(1'b1, 1, 1'b1, 1),
      row_item(1'b1, 32767, 1'b1, 32767),                   // quotient saturates high
      row_item(1'b1, -32768, 1'b0, 0),                      // and low
      row_csr(CSR_TEMP_DIV, 2047),
      row_csr(CSR_HUM_DIV, 2047),
      row_item(1'b1, -32768, 1'b1, 32767),
      row_csr(CSR_TEMP_DIV, 128),
      row_csr(CSR_HUM_DIV, 128),
      row_item(1'b1, 20480, 1'b1, 25600),
      row_csr(CSR_TEMP_DIV, 1024),
      row_csr(CSR_HUM_DIV, 1024),
      row_item(1'b1, -10240, 1'b1, 0),
      row_csr(CSR_TEMP_DIV, 256),
      row_csr(CSR_HUM_DIV, 256),
      row_csr(CSR_FAIL_LIMIT, 3)
   };

   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 45) begin
         return 0;
      end else if (r < 85) begin
         return int'($urandom_range(1, 3));
      end else if (r < 97) begin
         return int'($urandom_range(4, 12));
      end
      return int'($urandom_range(20, 80));
   endfunction

   // miss bursts long enough to reach any limit
   function automatic bit pick_valid(inout int burst);
      bit v;
      if (burst > 0) begin
         burst--;
         v = 1'b0;
      end else if ($urandom_range(0, 24) == 0) begin
         burst = int'($urandom_range(0, 8));
         v = 1'b0;
      end else begin
         v = ($urandom_range(0, 9) != 0);
      end
      return v;
   endfunction

   // raw reading whose scaled value lands near a threshold or the clamp
   function automatic longint near_reading(longint cur, int unsigned dv, longint thr_lo,
                                           longint thr_hi, longint lim,
                                           longint lo, longint hi);
      longint off;
      longint d;
      case ($urandom_range(0, 8))
         0: off = thr_lo;
         1: off = thr_lo + 1;
         2: off = thr_hi;
         3: off = thr_hi + 1;
         4: off = lim;
         5: off = lim + 1;
         6: off = 0;
         default: off = longint'($urandom_range(0, int'(3 * lim)));
      endcase
      if ($urandom_range(0, 1) == 1) off = -off;
      d = (dv == 0) ? 1 : longint'(dv);
      return clip_range(((cur + off) * d) / ONE, lo, hi);
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      s.temp_valid = pick_valid(temp_burst);
      s.hum_valid = pick_valid(hum_burst);
      case ($urandom_range(0, 9))
         0: s.temp_reading = READ_W'($urandom);
         1: begin
            case ($urandom_range(0, 5))
               0: s.temp_reading = READ_W'(-32768);
               1: s.temp_reading = READ_W'(32767);
               2: s.temp_reading = READ_W'(-10240);
               3: s.temp_reading = READ_W'(20480);
               4: s.temp_reading = READ_W'(0);
               default: s.temp_reading = READ_W'(-1);
            endcase
         end
         2, 3: s.temp_reading = READ_W'(int'($urandom_range(0, 30720)) - 10240);
         default: begin
            if (temp_loaded) begin
               s.temp_reading = READ_W'(near_reading(temp_est, cfg_temp_div, T_SMALL,
                                                     T_MED, T_CLAMP, -32768, 32767));
            end else begin
               s.temp_reading = READ_W'(int'($urandom_range(0, 30720)) - 10240);
            end
         end
      endcase
      case ($urandom_range(0, 9))
         0: s.hum_reading = HUM_READ_W'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: s.hum_reading = HUM_READ_W'(0);
               1: s.hum_reading = HUM_READ_W'(25600);
               2: s.hum_reading = HUM_READ_W'(32767);
               default: s.hum_reading = HUM_READ_W'(1);
            endcase
         end
         2, 3: s.hum_reading = HUM_READ_W'($urandom_range(0, 25600));
         default: begin
            if (hum_loaded) begin
               s.hum_reading = HUM_READ_W'(near_reading(hum_est, cfg_hum_div, H_SMALL,
                                                        H_MED, H_CLAMP, 0, 32767));
            end else begin
               s.hum_reading = HUM_READ_W'($urandom_range(0, 25600));
            end
         end
      endcase
      return s;
   endfunction

   // valid is left high after acceptance so back-to-back items need no toggle
   task automatic drive_sample(sample_type s, bit checked, sensor_out_type typed);
      int gap;
      sensor_out_type predicted;
      if (csr_open) begin
         csr_we <= 1'b0;
         csr_open = 1'b0;
      end
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_temp_valid <= s.temp_valid;
      req_temp_reading <= s.temp_reading;
      req_hum_valid <= s.hum_valid;
      req_hum_reading <= s.hum_reading;
      do @(posedge clock); while (!req_ready);
      predicted = advance_filters(s);
      pending_outputs.push_back(checked ? typed : predicted);
      items_sent++;
      items_open = 1'b1;
   endtask

   task automatic quiesce();
      if (items_open) begin
         req_valid <= 1'b0;
         items_open = 1'b0;
         while (pending_outputs.size() != 0) @(posedge clock);
         repeat (SETTLE) @(posedge clock);
      end
   endtask

   // write enable stays high; the next item or write decides what follows
   task automatic set_register(caem_csr_type idx, int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= DIV_W'(val);
      @(posedge clock);
      csr_open = 1'b1;
      regs_written++;
      case (idx)
         CSR_TEMP_DIV:   cfg_temp_div = val & ((1 << DIV_W) - 1);
         CSR_HUM_DIV:    cfg_hum_div = val & ((1 << DIV_W) - 1);
         CSR_FAIL_LIMIT: cfg_limit = val & ((1 << LIMIT_W) - 1);
         default: ;
      endcase
   endtask

   function automatic int unsigned random_divisor();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(0, (1 << DIV_W) - 1);
      end
      return $urandom_range(128, 1024);
   endfunction

   task automatic apply_setting(int p);
      int unsigned td;
      int unsigned hd;
      int unsigned lim;
      case (p)
         0: begin td = 256;  hd = 256;  lim = 3; end
         1: begin td = 128;  hd = 1024; lim = 7; end
         2: begin td = 1024; hd = 128;  lim = 1; end
         3: begin td = 0;    hd = 2047; lim = 0; end
         4: begin td = 2047; hd = 0;    lim = 2; end
         5: begin td = 256;  hd = 256;  lim = 7; end
         default: begin
            td = random_divisor();
            hd = random_divisor();
            lim = $urandom_range(0, 7);
         end
      endcase
      quiesce();
      set_register(CSR_TEMP_DIV, td);
      set_register(CSR_HUM_DIV, hd);
      set_register(CSR_FAIL_LIMIT, lim);
   endtask

   // ------------------------------------------------------------ processes

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_temp_valid <= 1'b0;
      req_temp_reading <= '0;
      req_hum_valid <= 1'b0;
      req_hum_reading <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_TEMP_DIV;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         case (script[i].kind)
            ROW_CSR: begin
               quiesce();
               set_register(script[i].csr_sel, int'(script[i].csr_val));
            end
            default: begin
               drive_sample(script[i].stim, script[i].kind == ROW_CHECKED,
                            script[i].typed_out);
            end
         endcase
      end
      directed_items = items_sent;

      for (int p = 0; p < PHASES; p++) begin
         apply_setting(p);
         calm = (p == 0 || p == 7);
         if (p == 2) squeeze_req = 1'b1;
         repeat (ITEMS_PER_PHASE) drive_sample(random_sample(), 1'b0, '0);
      end
      quiesce();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d items (%0d scripted) with %0d register writes; %0d results compared.",
               items_sent, directed_items, regs_written, results_checked);
      $display("Alpha bands slow/mid/fast: %0d/%0d/%0d; fault pulses temp %0d, hum %0d.",
               alpha_hits[0], alpha_hits[1], alpha_hits[2], temp_faults, hum_faults);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off that backs up the input
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (squeeze_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            squeeze_req = 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: repeat ($urandom_range(1, 4)) @(posedge clock);
               6, 7, 8: repeat ($urandom_range(5, 20)) @(posedge clock);
               default: repeat ($urandom_range(40, 100)) @(posedge clock);
            endcase
            rsp_ready <= 1'b0;
            if ($urandom_range(0, 99) < 92) begin
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end else begin
               repeat ($urandom_range(20, 60)) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      sensor_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            $error("result item with no item outstanding");
            errors++;
         end else begin
            want = pending_outputs.pop_front();
            results_checked++;
            temp_faults += int'(want.temp_fault);
            hum_faults += int'(want.hum_fault);
            if (rsp_temp_filtered !== want.temp_filtered) begin
               $error("temp_filtered: expected %0d, got %0d",
                      want.temp_filtered, rsp_temp_filtered);
               errors++;
            end
            if (rsp_hum_filtered !== want.hum_filtered) begin
               $error("hum_filtered: expected %0d, got %0d",
                      want.hum_filtered, rsp_hum_filtered);
               errors++;
            end
            if (rsp_temp_fault !== want.temp_fault) begin
               $error("temp_fault: expected %0d, got %0d", want.temp_fault, rsp_temp_fault);
               errors++;
            end
            if (rsp_hum_fault !== want.hum_fault) begin
               $error("hum_fault: expected %0d, got %0d", want.hum_fault, rsp_hum_fault);
               errors++;
            end
         end
      end
   end

   // no handshake on either side for too long means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
